// ===== sv/pulse_capture_queue_core_assert.svh =====
// assertion macros for the pulse capture queue
// used by the top level, no other dependencies
`ifndef PULSE_CAPTURE_QUEUE_CORE_ASSERT_SVH
`define PULSE_CAPTURE_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PCQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcq assertion failed");

// next-cycle implication, disabled in reset
`define PCQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcq assertion failed");

`endif

// ===== sv/pcq_pkg.sv =====
// shared types and constants for the pulse capture queue
// no dependencies
`timescale 1ns / 1ps

package pcq_pkg;

  localparam int CHANNELS_DEF    = 2;
  localparam int QUEUE_DEPTH_DEF = 64;

  localparam int ENTRY_W = 16;
  localparam int LEN_W   = 15;
  localparam int FILL_W  = 7;

  localparam logic [LEN_W-1:0] LEN_MAX = 15'h7fff;

  typedef enum logic [1:0] {
    OP_CAPTURE = 2'd0,
    OP_POP     = 2'd1,
    OP_COUNT   = 2'd2
  } op_t;

  typedef struct packed {
    logic              valid_res;
    logic [LEN_W-1:0]  pulse_length;
    logic              pulse_level;
    logic              next_edge_rising;
    logic [FILL_W-1:0] fill_count;
  } result_t;

endpackage

// ===== sv/pcq_req_if.sv =====
// request channel: capture, pop and count items
// depends on nothing
`timescale 1ns / 1ps

interface pcq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic        channel;
  logic [15:0] capture_value;

  modport source (output valid, operation, channel, capture_value, input ready);
  modport sink   (input valid, operation, channel, capture_value, output ready);
endinterface

// ===== sv/pcq_rsp_if.sv =====
// response channel: one result item per request item
// depends on nothing
`timescale 1ns / 1ps

interface pcq_rsp_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [14:0] pulse_length;
  logic        pulse_level;
  logic        next_edge_rising;
  logic [6:0]  fill_count;

  modport source (output valid, valid_res, pulse_length, pulse_level,
                  next_edge_rising, fill_count, input ready);
  modport sink   (input valid, valid_res, pulse_length, pulse_level,
                  next_edge_rising, fill_count, output ready);
endinterface

// ===== sv/pcq_store.sv =====
// pulse storage ram, all channel fifos side by side, registered read
// depends on pcq_pkg
`timescale 1ns / 1ps

module pcq_store #(
  parameter int CHANNELS    = pcq_pkg::CHANNELS_DEF,
  parameter int QUEUE_DEPTH = pcq_pkg::QUEUE_DEPTH_DEF,
  localparam int DEPTH      = CHANNELS * QUEUE_DEPTH,
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [pcq_pkg::ENTRY_W-1:0]  wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [pcq_pkg::ENTRY_W-1:0]  rdata
);
  import pcq_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/pulse_capture_queue_core.sv =====
// pulse capture queue: per-channel edge timing recorder with pulse fifos
// an accepted item is registered in stage 1, then in the output register, which offers its result item
// throughput: one item per cycle while the sink keeps ready high; channel state updates at accept
// a stalled sink holds the input once the read stage and the output register are both occupied
// reset (rst, synchronous): levels high, captures, pointers and counts zero
// the pulse ram is not cleared; the fill counts guard every read of it
`timescale 1ns / 1ps
`include "pulse_capture_queue_core_assert.svh"

module pulse_capture_queue_core #(
  parameter int CHANNELS    = pcq_pkg::CHANNELS_DEF,
  parameter int QUEUE_DEPTH = pcq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  pcq_req_if.sink     req,
  pcq_rsp_if.source   rsp
);
  import pcq_pkg::*;

  localparam int DEPTH = CHANNELS * QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // per-channel control state, small enough to live in flops
  logic [ENTRY_W-1:0] prev  [CHANNELS];
  logic               level [CHANNELS];
  logic [PW-1:0]      rptr  [CHANNELS];
  logic [PW-1:0]      wptr  [CHANNELS];
  logic [CW-1:0]      cnt   [CHANNELS];

  // request decode
  logic               accept;
  logic               ch_ok;
  logic [CHW-1:0]     ch_idx;
  logic [ENTRY_W-1:0] cur_prev;
  logic               cur_level;
  logic [PW-1:0]      cur_rptr;
  logic [PW-1:0]      cur_wptr;
  logic [CW-1:0]      cur_cnt;
  logic [ENTRY_W-1:0] diff;
  logic [LEN_W-1:0]   len_sat;
  logic               full;
  logic               empty;
  logic [CW-1:0]      fill_next;
  logic [31:0]        fill_wide;
  result_t            item;
  logic               use_mem;
  logic               do_capture;
  logic               do_push;
  logic               do_pop;

  // ram port
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;

  // stage 1 waits for the ram read, output register parts from the sink
  logic               s1_valid;
  result_t            s1_item;
  logic               s1_use_mem;
  logic               s1_move;
  result_t            s1_merged;
  logic               out_valid;
  result_t            out_item;

  assign s1_move   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_move;
  assign accept    = req.valid && req.ready;

  assign ch_ok     = 32'(req.channel) < CHANNELS;
  assign ch_idx    = CHW'(req.channel);
  assign cur_prev  = prev[ch_idx];
  assign cur_level = level[ch_idx];
  assign cur_rptr  = rptr[ch_idx];
  assign cur_wptr  = wptr[ch_idx];
  assign cur_cnt   = cnt[ch_idx];

  // elapsed ticks wrap at 16 bits, then clamp to the 15-bit field
  assign diff    = req.capture_value - cur_prev;
  assign len_sat = diff[ENTRY_W-1] ? LEN_MAX : diff[LEN_W-1:0];
  assign full    = cur_cnt == CW'(QUEUE_DEPTH);
  assign empty   = cur_cnt == '0;

  always_comb begin
    item       = '0;
    use_mem    = 1'b0;
    fill_next  = cur_cnt;
    do_capture = 1'b0;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    if (ch_ok) begin
      case (req.operation)
        OP_CAPTURE: begin
          // the level before the edge is what the pulse measured
          item.valid_res        = !full;
          item.pulse_length     = len_sat;
          item.pulse_level      = cur_level;
          item.next_edge_rising = !cur_level;
          fill_next             = full ? cur_cnt : cur_cnt + CW'(1);
          do_capture            = accept;
          do_push               = accept && !full;
        end
        OP_POP: begin
          // length and level come back from the registered ram read in the next cycle
          item.valid_res        = !empty;
          item.next_edge_rising = cur_level;
          fill_next             = empty ? cur_cnt : cur_cnt - CW'(1);
          use_mem               = !empty;
          do_pop                = accept && !empty;
        end
        OP_COUNT: begin
          item.valid_res        = 1'b1;
          item.next_edge_rising = cur_level;
        end
        default: begin
          fill_next = '0;
        end
      endcase
    end else begin
      fill_next = '0;
    end
    fill_wide       = 32'(fill_next);
    item.fill_count = fill_wide[FILL_W-1:0];
  end

  // each channel owns a contiguous slice of the ram
  assign mem_we    = do_push;
  assign mem_re    = do_pop;
  assign mem_waddr = AW'(32'(ch_idx) * QUEUE_DEPTH) + AW'(cur_wptr);
  assign mem_raddr = AW'(32'(ch_idx) * QUEUE_DEPTH) + AW'(cur_rptr);
  assign mem_wdata = {cur_level, len_sat};

  pcq_store #(
    .CHANNELS    (CHANNELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // per-channel state is updated at accept, so the next item sees it at once
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        prev[i]  <= '0;
        level[i] <= 1'b1;
        rptr[i]  <= '0;
        wptr[i]  <= '0;
        cnt[i]   <= '0;
      end
    end else begin
      if (do_capture) begin
        prev[ch_idx]  <= req.capture_value;
        level[ch_idx] <= !cur_level;
      end
      if (do_push) begin
        wptr[ch_idx] <= (cur_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : cur_wptr + PW'(1);
      end
      if (do_pop) begin
        rptr[ch_idx] <= (cur_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : cur_rptr + PW'(1);
      end
      if (do_push || do_pop) begin
        cnt[ch_idx] <= fill_next;
      end
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pop items take length and level from the ram read
  always_comb begin
    s1_merged = s1_item;
    if (s1_use_mem) begin
      s1_merged.pulse_length = mem_rdata[LEN_W-1:0];
      s1_merged.pulse_level  = mem_rdata[ENTRY_W-1];
    end
  end

  // payload, no reset; ram data holds until the next pop is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item    <= item;
      s1_use_mem <= use_mem;
    end
    if (s1_move) begin
      out_item <= s1_merged;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.valid_res        = out_item.valid_res;
  assign rsp.pulse_length     = out_item.pulse_length;
  assign rsp.pulse_level      = out_item.pulse_level;
  assign rsp.next_edge_rising = out_item.next_edge_rising;
  assign rsp.fill_count       = out_item.fill_count;

  // checks
  `PCQ_ASSERT_NOW(a_cnt_bound, clk, rst, accept && ch_ok, cur_cnt <= CW'(QUEUE_DEPTH))
  `PCQ_ASSERT_NOW(a_stall_blocks, clk, rst, s1_valid && out_valid && !rsp.ready, !req.ready)
  `PCQ_ASSERT_NOW(a_out_from_s1, clk, rst, $rose(out_valid), $past(s1_valid))

endmodule

// ===== tb/sv/tb_pulse_capture_queue_core.sv =====
// self-checking testbench for pulse_capture_queue_core: drives capture, pop and count
// items and checks every result item against a cycle-free predictor of the pulse fifos
// depends on pcq_pkg, pcq_req_if, pcq_rsp_if and the core
`timescale 1ns / 1ps

module tb_pulse_capture_queue_core;
  import pcq_pkg::*;

  localparam int NUM_CH = CHANNELS_DEF;
  localparam int DEPTH  = QUEUE_DEPTH_DEF;

  // operation code the block leaves unused, must answer with an all-zero item
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // settle time at the end, after the last expected result item
  localparam int SETTLE_CYCLES = 20;
  // watchdog bound on the whole run
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pcq_req_if req ();
  pcq_rsp_if rsp ();

  pulse_capture_queue_core #(
    .CHANNELS   (NUM_CH),
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: one pulse fifo per channel plus edge tracking
  // ---------------------------------------------------------------------------
  logic [15:0] ch_prev_stamp [NUM_CH];
  logic        ch_level      [NUM_CH];
  logic [15:0] ch_mem        [NUM_CH][DEPTH];  // {level, length}
  int          ch_head       [NUM_CH];
  int          ch_tail       [NUM_CH];
  int          ch_fill       [NUM_CH];

  result_t pending_results[$];  // expected result items, oldest first

  int mismatch_count  = 0;
  int cycle_count     = 0;
  int gap_pct         = 0;    // chance of a sender gap after each item
  int stall_pct       = 0;    // chance of a receiver stall burst
  int stall_left      = 0;
  int hold_off_cycles = 0;    // long receiver hold-off, counted down below

  // works out the result item for one request and advances the fifo state
  function automatic result_t predict_pulse_result(logic [1:0] op, logic ch,
                                                   logic [15:0] stamp);
    result_t     r;
    logic [15:0] delta;
    logic [15:0] entry;
    int          c;
    r = '0;
    c = int'(ch);
    // bad channel or unused code: all-zero item, nothing changes
    if (c >= NUM_CH || op == OP_UNUSED) return r;
    case (op)
      OP_CAPTURE: begin
        // elapsed ticks modulo 2^16, anything with the top bit set saturates
        delta = stamp - ch_prev_stamp[c];
        r.pulse_length = delta[15] ? LEN_MAX : delta[LEN_W-1:0];
        r.pulse_level  = ch_level[c];
        ch_prev_stamp[c] = stamp;
        // full fifo drops the pulse but still tracks the edge
        if (ch_fill[c] < DEPTH) begin
          ch_mem[c][ch_tail[c]] = {r.pulse_level, r.pulse_length};
          ch_tail[c] = (ch_tail[c] + 1) % DEPTH;
          ch_fill[c]++;
          r.valid_res = 1'b1;
        end
        ch_level[c] = ~ch_level[c];
      end
      OP_POP: begin
        // empty pop leaves length and level at zero
        if (ch_fill[c] > 0) begin
          entry = ch_mem[c][ch_head[c]];
          r.pulse_length = entry[LEN_W-1:0];
          r.pulse_level  = entry[15];
          ch_head[c] = (ch_head[c] + 1) % DEPTH;
          ch_fill[c]--;
          r.valid_res = 1'b1;
        end
      end
      default: begin
        // count query on a good channel always answers valid
        r.valid_res = 1'b1;
      end
    endcase
    r.next_edge_rising = ch_level[c];
    r.fill_count       = FILL_W'(ch_fill[c]);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offers one item, holds it until taken, then maybe idles for a burst
  task automatic issue_request(logic [1:0] op, logic ch, logic [15:0] stamp);
    req.valid         <= 1'b1;
    req.operation     <= op;
    req.channel       <= ch;
    req.capture_value <= stamp;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(predict_pulse_result(op, ch, stamp));
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // timer values: full range, tiny steps, steps near the saturation point, any step
  function automatic logic [15:0] pick_stamp(logic ch);
    logic [15:0] prev;
    prev = ch_prev_stamp[int'(ch)];
    case ($urandom_range(3))
      0:       return 16'($urandom_range(16'hffff));
      1:       return prev + 16'($urandom_range(0, 40));
      2:       return prev + 16'($urandom_range(16'h7ff0, 16'h8010));
      default: return prev + 16'($urandom_range(16'hffff));
    endcase
  endfunction

  // weighted operation choice, a few unused codes mixed in
  function automatic logic [1:0] pick_op(int capture_weight);
    int r;
    r = $urandom_range(99);
    if (r < capture_weight) return OP_CAPTURE;
    if (r < 97) return ($urandom_range(3) == 0) ? OP_COUNT : OP_POP;
    return OP_UNUSED;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes of the length math, empty pops, unused code, both channels
  task automatic test_directed();
    gap_pct   = 20;
    stall_pct = 20;
    issue_request(OP_COUNT,   1'b0, 16'h0000);
    issue_request(OP_COUNT,   1'b1, 16'h0000);
    issue_request(OP_POP,     1'b0, 16'h0000);  // empty fifo
    issue_request(OP_CAPTURE, 1'b0, 16'h0000);  // equal to reset stamp, zero length
    issue_request(OP_CAPTURE, 1'b0, 16'h7fff);  // largest unsaturated length
    issue_request(OP_CAPTURE, 1'b0, 16'hffff);  // step of 0x8000, saturates
    issue_request(OP_CAPTURE, 1'b0, 16'h0000);  // timer wrap, length 1
    issue_request(OP_CAPTURE, 1'b0, 16'h0000);  // equal captures
    issue_request(OP_CAPTURE, 1'b1, 16'haaaa);
    issue_request(OP_CAPTURE, 1'b1, 16'h5555);
    issue_request(OP_CAPTURE, 1'b1, 16'hffff);
    issue_request(OP_UNUSED,  1'b0, 16'hffff);
    issue_request(OP_UNUSED,  1'b1, 16'h1234);
    issue_request(OP_COUNT,   1'b0, 16'hffff);
    issue_request(OP_COUNT,   1'b1, 16'h0000);
    repeat (6) issue_request(OP_POP, 1'b0, 16'h0000);  // drain, last one empty
    repeat (4) issue_request(OP_POP, 1'b1, 16'hffff);
    issue_request(OP_COUNT,   1'b1, 16'h0000);
  endtask

  // fill each fifo past full so pulses drop, then drain past empty
  task automatic test_fill_overflow();
    gap_pct   = 10;
    stall_pct = 15;
    for (int c = 0; c < NUM_CH; c++) begin
      repeat (DEPTH + 3) issue_request(OP_CAPTURE, c[0], pick_stamp(c[0]));
      issue_request(OP_COUNT, c[0], 16'($urandom_range(16'hffff)));
      repeat (DEPTH + 2) issue_request(OP_POP, c[0], 16'($urandom_range(16'hffff)));
      issue_request(OP_COUNT, c[0], 16'($urandom_range(16'hffff)));
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    logic ch;
    gap_pct         = 0;
    stall_pct       = 0;
    hold_off_cycles = 200;
    repeat (80) begin
      ch = 1'($urandom_range(1));
      issue_request(pick_op(70), ch, pick_stamp(ch));
    end
  endtask

  // segments with their own mix of operations and idling, so fill levels
  // swing between empty and full and gaps land on every phase
  task automatic test_random_mix();
    int   weight;
    logic ch;
    for (int seg = 0; seg < 10; seg++) begin
      case ($urandom_range(2))
        0:       weight = 70;
        1:       weight = 45;
        default: weight = 20;
      endcase
      gap_pct   = 25 * $urandom_range(2);
      stall_pct = 25 * $urandom_range(2);
      repeat (85) begin
        ch = 1'($urandom_range(1));
        issue_request(pick_op(weight), ch, pick_stamp(ch));
      end
    end
  endtask

  // full rate on both sides to close the run
  task automatic test_no_idle();
    logic ch;
    gap_pct   = 0;
    stall_pct = 0;
    repeat (150) begin
      ch = 1'($urandom_range(1));
      issue_request(pick_op(50), ch, pick_stamp(ch));
    end
  endtask

  // ---------------------------------------------------------------------------
  // response side
  // ---------------------------------------------------------------------------

  // ready: low in reset, then long hold-off, random stall bursts, or high
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      rsp.ready <= 1'b0;
      hold_off_cycles--;
    end else if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left--;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      rsp.ready <= 1'b0;
      stall_left = $urandom_range(0, 9);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // every taken result item is matched against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t oldest;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no expectation pending");
        mismatch_count++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("valid_res",        oldest.valid_res,        rsp.valid_res);
        check_field("pulse_length",     oldest.pulse_length,     rsp.pulse_length);
        check_field("pulse_level",      oldest.pulse_level,      rsp.pulse_level);
        check_field("next_edge_rising", oldest.next_edge_rising, rsp.next_edge_rising);
        check_field("fill_count",       oldest.fill_count,       rsp.fill_count);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL pulse_capture_queue_core");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    req.valid         <= 1'b0;
    req.operation     <= OP_CAPTURE;
    req.channel       <= 1'b0;
    req.capture_value <= 16'h0000;
    // state after reset: lines high, stamps zero, fifos empty
    for (int c = 0; c < NUM_CH; c++) begin
      ch_prev_stamp[c] = 16'h0000;
      ch_level[c]      = 1'b1;
      ch_head[c]       = 0;
      ch_tail[c]       = 0;
      ch_fill[c]       = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill_overflow();
    test_backpressure();
    test_random_mix();
    test_no_idle();

    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // catch any stray result item after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS pulse_capture_queue_core");
    end else begin
      $display("FAIL pulse_capture_queue_core");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/pcq_pkg.sv
sv/pcq_req_if.sv
sv/pcq_rsp_if.sv
sv/pcq_store.sv
sv/pulse_capture_queue_core.sv
tb/sv/tb_pulse_capture_queue_core.sv
